[src/plf_pkg.sv]
package plf_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_SPEED        = 2'd0;
  localparam logic [1:0] REG_LINE_CENTER      = 2'd1;
  localparam logic [1:0] REG_LOST_THRESHOLD   = 2'd2;
  localparam logic [1:0] REG_BRANCH_THRESHOLD = 2'd3;

  localparam logic [7:0]  MAX_SPEED_RST        = 8'd95;
  localparam logic [11:0] LINE_CENTER_RST      = 12'd2000;
  localparam logic [9:0]  LOST_THRESHOLD_RST   = 10'd100;
  localparam logic [9:0]  BRANCH_THRESHOLD_RST = 10'd200;

  // x / 20 == (x * 3277) >> 16 for 0 <= x < 4096
  localparam logic [11:0] RECIP_20     = 12'd3277;
  localparam int          RECIP_20_SH  = 16;
  // x / 10000 == (x * 3518437209) >> 45 for 0 <= x <= 2^31
  localparam logic [31:0] RECIP_10K    = 32'd3518437209;
  localparam int          RECIP_10K_SH = 45;

  localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  // after the integrator
  typedef struct packed {
    logic signed [12:0] err;
    logic signed [13:0] deriv;
    logic signed [31:0] sum;
    logic               seg_end;
  } integ_t;

  // after the small divides and the magnitude of the integral
  typedef struct packed {
    logic signed [8:0]  err_q;
    logic signed [14:0] d_half;
    logic               sum_neg;
    logic [31:0]        sum_mag;
    logic               seg_end;
  } scale_t;

  // after the integral reciprocal multiply
  typedef struct packed {
    logic signed [8:0]  err_q;
    logic signed [14:0] d_half;
    logic               sum_neg;
    logic [63:0]        prod;
    logic               seg_end;
  } prod_t;

endpackage

[src/pid_line_follower_step.sv]
// each item passes the input, integrator, scale, product and output registers
// throughput: one item per cycle while out_tready is high; the integrator update
// is a single saturating add in one stage, so running state never limits the rate
// each stage holds its item while the next is full, so input keeps flowing
// while a finished result waits on out_tready, until all five stages hold an item
// reset (rst_n low, synchronous): pipeline empty, integral and last error zero,
// registers back to max_speed 95, line_center 2000, thresholds 100 and 200
module pid_line_follower_step (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  // sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] line_position, [21:12] sensor_far_left, [31:22] sensor_left,
  // [41:32] sensor_middle, [51:42] sensor_right, [61:52] sensor_far_right,
  // [63:62] zero
  input  logic [63:0] in_tdata,
  // [0] start_segment
  input  logic        in_tuser,
  // drive stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] left_drive, [15:8] right_drive
  output logic [15:0] out_tdata,
  // [0] segment_end
  output logic        out_tuser
);
  import plf_pkg::*;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [7:0]  max_speed_r;
  logic [11:0] line_center_r;
  logic [9:0]  lost_thr_r;
  logic [9:0]  branch_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= MAX_SPEED_RST;
      line_center_r <= LINE_CENTER_RST;
      lost_thr_r    <= LOST_THRESHOLD_RST;
      branch_thr_r  <= BRANCH_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_SPEED:        max_speed_r   <= cfg_wdata[7:0];
        REG_LINE_CENTER:      line_center_r <= cfg_wdata;
        REG_LOST_THRESHOLD:   lost_thr_r    <= cfg_wdata[9:0];
        REG_BRANCH_THRESHOLD: branch_thr_r  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage valids and per-stage ready chain
  // ---------------------------------------------------------------------
  logic v_in_r, v_int_r, v_scl_r, v_prd_r, v_out_r;
  logic rdy_out, rdy_prd, rdy_scl, rdy_int;
  logic ld_int;

  assign rdy_out   = !v_out_r || out_tready;
  assign rdy_prd   = !v_prd_r || rdy_out;
  assign rdy_scl   = !v_scl_r || rdy_prd;
  assign rdy_int   = !v_int_r || rdy_scl;
  assign in_tready = !v_in_r  || rdy_int;
  // an item leaves the input register exactly once: that is when state moves
  assign ld_int    = v_in_r && rdy_int;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r  <= 1'b0;
      v_int_r <= 1'b0;
      v_scl_r <= 1'b0;
      v_prd_r <= 1'b0;
      v_out_r <= 1'b0;
    end else begin
      if (in_tready) v_in_r  <= in_tvalid;
      if (rdy_int)   v_int_r <= v_in_r;
      if (rdy_scl)   v_scl_r <= v_int_r;
      if (rdy_prd)   v_prd_r <= v_scl_r;
      if (rdy_out)   v_out_r <= v_prd_r;
    end
  end

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  logic        start_r;
  logic [11:0] pos_r;
  logic [9:0]  s_fl_r, s_l_r, s_m_r, s_rt_r, s_fr_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      start_r <= in_tuser;
      pos_r   <= in_tdata[11:0];
      s_fl_r  <= in_tdata[21:12];
      s_l_r   <= in_tdata[31:22];
      s_m_r   <= in_tdata[41:32];
      s_rt_r  <= in_tdata[51:42];
      s_fr_r  <= in_tdata[61:52];
    end
  end

  // ---------------------------------------------------------------------
  // integrator: error, derivative, saturating running sum, segment flag
  // ---------------------------------------------------------------------
  logic signed [31:0] error_sum_r, error_sum_nxt;
  logic signed [12:0] prev_err_r;
  logic signed [12:0] err, prev_eff;
  logic signed [31:0] sum_base;
  logic signed [32:0] sum_wide;
  logic               lost, branch;
  integ_t             integ_nxt, integ_r;

  always_comb begin
    err      = $signed({1'b0, pos_r}) - $signed({1'b0, line_center_r});
    prev_eff = start_r ? 13'sd0 : prev_err_r;
    sum_base = start_r ? 32'sd0 : error_sum_r;
    sum_wide = {sum_base[31], sum_base} + {{20{err[12]}}, err};
    // overflow when the two top bits disagree; the top bit gives the side
    if (sum_wide[32] != sum_wide[31]) begin
      error_sum_nxt = sum_wide[32] ? SUM_MIN : SUM_MAX;
    end else begin
      error_sum_nxt = sum_wide[31:0];
    end
    lost   = (s_l_r < lost_thr_r) && (s_m_r < lost_thr_r) && (s_rt_r < lost_thr_r);
    branch = (s_fl_r > branch_thr_r) || (s_fr_r > branch_thr_r);

    integ_nxt.err     = err;
    integ_nxt.deriv   = {err[12], err} - {prev_eff[12], prev_eff};
    integ_nxt.sum     = error_sum_nxt;
    integ_nxt.seg_end = lost || branch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= 32'sd0;
      prev_err_r  <= 13'sd0;
    end else if (ld_int) begin
      error_sum_r <= error_sum_nxt;
      prev_err_r  <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_int) integ_r <= integ_nxt;
  end

  // ---------------------------------------------------------------------
  // error / 20, derivative * 3 / 2, magnitude of the integral
  // ---------------------------------------------------------------------
  logic               err_neg;
  logic [11:0]        err_mag;
  logic [23:0]        err_prod;
  logic [7:0]         err_div;
  logic signed [15:0] d3;
  scale_t             scale_nxt, scale_r;

  always_comb begin
    err_neg  = integ_r.err[12];
    err_mag  = err_neg ? 12'(-integ_r.err) : integ_r.err[11:0];
    err_prod = err_mag * RECIP_20;
    err_div  = err_prod[23:RECIP_20_SH];
    d3       = {{2{integ_r.deriv[13]}}, integ_r.deriv} * 16'sd3;

    scale_nxt.err_q   = err_neg ? -$signed({1'b0, err_div}) : $signed({1'b0, err_div});
    // halve rounding toward zero: bias negatives by one before the shift
    scale_nxt.d_half  = 15'((d3 + {15'd0, d3[15]}) >>> 1);
    scale_nxt.sum_neg = integ_r.sum[31];
    scale_nxt.sum_mag = integ_r.sum[31] ? 32'(-integ_r.sum) : integ_r.sum;
    scale_nxt.seg_end = integ_r.seg_end;
  end

  always_ff @(posedge clk) begin
    if (v_int_r && rdy_scl) scale_r <= scale_nxt;
  end

  // ---------------------------------------------------------------------
  // integral / 10000 by reciprocal multiply
  // ---------------------------------------------------------------------
  prod_t prod_r;

  always_ff @(posedge clk) begin
    if (v_scl_r && rdy_prd) begin
      prod_r.err_q   <= scale_r.err_q;
      prod_r.d_half  <= scale_r.d_half;
      prod_r.sum_neg <= scale_r.sum_neg;
      prod_r.prod    <= scale_r.sum_mag * RECIP_10K;
      prod_r.seg_end <= scale_r.seg_end;
    end
  end

  // ---------------------------------------------------------------------
  // steering sum, clamp and wheel split
  // ---------------------------------------------------------------------
  logic [18:0]        sum_div;
  logic signed [19:0] sum_q, diff, top, diff_c;
  logic [7:0]         left_nxt, right_nxt;
  logic [7:0]         left_r, right_r;
  logic               seg_end_r;

  always_comb begin
    sum_div = prod_r.prod[63:RECIP_10K_SH];
    sum_q   = prod_r.sum_neg ? -$signed({1'b0, sum_div}) : $signed({1'b0, sum_div});
    diff    = {{11{prod_r.err_q[8]}}, prod_r.err_q}
            + {{5{prod_r.d_half[14]}}, prod_r.d_half}
            + sum_q;
    top     = $signed({12'd0, max_speed_r});
    if (diff > top) begin
      diff_c = top;
    end else if (diff < -top) begin
      diff_c = -top;
    end else begin
      diff_c = diff;
    end
    // negative difference slows the left wheel, positive the right
    if (diff_c < 0) begin
      left_nxt  = 8'(top + diff_c);
      right_nxt = max_speed_r;
    end else begin
      left_nxt  = max_speed_r;
      right_nxt = 8'(top - diff_c);
    end
  end

  always_ff @(posedge clk) begin
    if (v_prd_r && rdy_out) begin
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      seg_end_r <= prod_r.seg_end;
    end
  end

  assign out_tvalid = v_out_r;
  assign out_tdata  = {right_r, left_r};
  assign out_tuser  = seg_end_r;

endmodule

[bench/pid_line_follower_step_test.sv]
module pid_line_follower_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plf_pkg::*;

  // settling margin after the expected results have drained
  localparam int SETTLE_CYCLES = 10;
  // wait limit for the expected results to drain
  localparam int DRAIN_LIMIT = 20000;
  // long receiver hold-off so the pipeline fills and in_tready drops
  localparam int HOLD_CYCLES = 300;
  // length of each full-scale error run
  localparam int FULL_RUN = 12;

  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -ACC_HI - 1;

  // one sensor sample as it travels on the input stream
  typedef struct packed {
    logic            start;
    logic [11:0]     pos;
    logic [4:0][9:0] sense;  // [0] far left .. [4] far right
  } sample_t;

  // one drive command as it leaves the block
  typedef struct packed {
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic       seg_end;
  } drive_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [11:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [11:0] line_position, [21:12] sensor_far_left, [31:22] sensor_left,
  // [41:32] sensor_middle, [51:42] sensor_right, [61:52] sensor_far_right,
  // [63:62] zero
  logic [63:0] in_tdata = '0;
  // [0] start_segment
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] left_drive, [15:8] right_drive
  logic [15:0] out_tdata;
  // [0] segment_end
  logic        out_tuser;

  // register copies kept by the predictor
  logic [7:0]  lim_speed    = MAX_SPEED_RST;
  logic [11:0] center_pos   = LINE_CENTER_RST;
  logic [9:0]  lost_level   = LOST_THRESHOLD_RST;
  logic [9:0]  branch_level = BRANCH_THRESHOLD_RST;

  // controller state kept by the predictor
  logic signed [31:0] integ_acc = '0;
  logic signed [12:0] last_err  = '0;

  drive_t expected_drives[$];
  int     drive_errors = 0;

  // random idling on both sides when set
  bit idle_on = 1'b0;
  // bumped by a test to ask the receiver for one long hold-off
  int hold_reqs = 0;

  pid_line_follower_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // steering step: error, slope, saturating integral, clamp, wheel split, segment end
  function automatic drive_t steer_predict(sample_t s);
    longint err_now, slope, acc, steer, top;
    drive_t r;
    // a new segment clears the integral and the last error first
    if (s.start) begin
      integ_acc = '0;
      last_err  = '0;
    end
    err_now = longint'(s.pos) - longint'(center_pos);
    slope   = err_now - longint'(last_err);
    acc     = longint'(integ_acc) + err_now;
    // integral saturates at the 32-bit signed limits
    if (acc > ACC_HI) begin
      acc = ACC_HI;
    end else if (acc < ACC_LO) begin
      acc = ACC_LO;
    end
    integ_acc = acc[31:0];
    last_err  = err_now[12:0];
    // all divides truncate toward zero
    steer = err_now / 20 + acc / 10000 + (slope * 3) / 2;
    top   = longint'(lim_speed);
    if (steer > top) begin
      steer = top;
    end else if (steer < -top) begin
      steer = -top;
    end
    // negative steering slows the left wheel, positive the right one
    r.left_drive  = (steer < 0) ? 8'(top + steer) : 8'(top);
    r.right_drive = (steer < 0) ? 8'(top) : 8'(top - steer);
    r.seg_end = (s.sense[1] < lost_level && s.sense[2] < lost_level &&
                 s.sense[3] < lost_level) ||
                s.sense[0] > branch_level || s.sense[4] > branch_level;
    return r;
  endfunction

  // drive result check: each transfer against the oldest expectation
  always @(posedge clk) begin : check_drive
    drive_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.left_drive  = out_tdata[7:0];
      got.right_drive = out_tdata[15:8];
      got.seg_end     = out_tuser;
      if (expected_drives.size() == 0) begin
        drive_errors++;
        if (drive_errors <= 10)
          $display("%0t: drive transfer with nothing expected: left %0d right %0d end %0b",
                   $realtime, got.left_drive, got.right_drive, got.seg_end);
      end else begin
        want = expected_drives.pop_front();
        if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
            got.seg_end !== want.seg_end) begin
          drive_errors++;
          if (drive_errors <= 10)
            $display("%0t: drive mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                     $realtime, want.left_drive, want.right_drive, want.seg_end,
                     got.left_drive, got.right_drive, got.seg_end);
        end
      end
    end
  end

  // receiver side: long hold-off on request, else random stall bursts
  always @(negedge clk) begin : drain
    int holds_taken, hold_left, stall_left;
    if (hold_reqs != holds_taken) begin
      holds_taken++;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      // start a random stall burst
      stall_left = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // one sample transfer, called at a falling edge and returning at one
  task automatic send_sample(sample_t s);
    int gap;
    // random sender gap now and then
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, s.sense, s.pos};
    in_tuser  <= s.start;
    do @(posedge clk); while (!in_tready);
    expected_drives.push_back(steer_predict(s));
    @(negedge clk);
  endtask

  // stop offering and let every expected drive come out
  task automatic quiesce();
    int spin;
    in_tvalid <= 1'b0;
    spin = 0;
    while (expected_drives.size() != 0 && spin < DRAIN_LIMIT) begin
      @(negedge clk);
      spin++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // all four registers, written only with the block idle
  task automatic program_regs(logic [11:0] speed, logic [11:0] center,
                              logic [11:0] lost, logic [11:0] branch);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MAX_SPEED;
    cfg_wdata <= speed;
    @(negedge clk);
    cfg_addr  <= REG_LINE_CENTER;
    cfg_wdata <= center;
    @(negedge clk);
    cfg_addr  <= REG_LOST_THRESHOLD;
    cfg_wdata <= lost;
    @(negedge clk);
    cfg_addr  <= REG_BRANCH_THRESHOLD;
    cfg_wdata <= branch;
    @(negedge clk);
    cfg_we <= 1'b0;
    // upper bits beyond each register width are dropped
    lim_speed    = speed[7:0];
    center_pos   = center;
    lost_level   = lost[9:0];
    branch_level = branch[9:0];
  endtask

  function automatic sample_t sample_of(logic start, logic [11:0] pos, logic [9:0] fl,
                                        logic [9:0] l, logic [9:0] m, logic [9:0] r,
                                        logic [9:0] fr);
    sample_t s;
    s.start = start;
    s.pos   = pos;
    s.sense = {fr, r, m, l, fl};
    return s;
  endfunction

  // random reflectance inside lo..hi, clipped to the 10-bit range
  function automatic logic [9:0] span(int lo, int hi);
    if (lo < 0) lo = 0;
    if (lo > 1023) lo = 1023;
    if (hi > 1023) hi = 1023;
    if (hi < lo) hi = lo;
    return 10'($urandom_range(hi, lo));
  endfunction

  // sensor picture: line under the middle, lost, branch, threshold edges, noise
  function automatic logic [4:0][9:0] scene_sensors();
    logic [4:0][9:0] v;
    int scene, k, th;
    bit outer;
    scene = $urandom_range(0, 4);
    for (k = 0; k < 5; k++) begin
      outer = (k == 0 || k == 4);
      th = outer ? int'(branch_level) : int'(lost_level);
      case (scene)
        0: v[k] = outer ? span(0, th) : span(th, 1023);
        1: v[k] = outer ? span(0, th) : span(0, th - 1);
        2: v[k] = outer ? span(th + 1, 1023) : span(0, 1023);
        3: v[k] = span(th - 1, th + 1);
        default: v[k] = span(0, 1023);
      endcase
    end
    // branch on one side only now and then
    if (scene == 2 && $urandom_range(0, 1) == 0)
      v[$urandom_range(0, 1) * 4] = span(0, int'(branch_level));
    return v;
  endfunction

  function automatic sample_t track_sample(bit first, logic [11:0] pos);
    sample_t s;
    // mostly only the first sample of a segment starts it
    s.start = first || ($urandom_range(0, 39) == 0);
    s.pos   = pos;
    s.sense = scene_sensors();
    return s;
  endfunction

  function automatic sample_t noise_sample();
    sample_t s;
    int k;
    s.start = 1'($urandom_range(0, 1));
    s.pos   = 12'($urandom_range(0, 4095));
    for (k = 0; k < 5; k++) s.sense[k] = 10'($urandom_range(0, 1023));
    return s;
  endfunction

  // small random walk of the line position, with an odd jump
  function automatic logic [11:0] walk_pos(logic [11:0] p);
    int v;
    if ($urandom_range(0, 29) == 0) begin
      v = $urandom_range(0, 4095);
    end else begin
      v = int'(p) + int'($urandom_range(0, 16)) - 8;
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  function automatic logic [11:0] near_center();
    int v;
    v = int'(center_pos) + int'($urandom_range(0, 1200)) - 600;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // reset values: centering, small steering both ways, sensor thresholds
  task automatic test_reset_defaults();
    idle_on = 1'b0;
    send_sample(sample_of(1'b1, 12'd2000, 10'd0, 10'd500, 10'd500, 10'd500, 10'd0));
    send_sample(sample_of(1'b0, 12'd2010, 10'd0, 10'd500, 10'd500, 10'd500, 10'd0));
    send_sample(sample_of(1'b0, 12'd1990, 10'd0, 10'd500, 10'd500, 10'd500, 10'd0));
    // lost line just below the threshold, then one middle sensor at it
    send_sample(sample_of(1'b0, 12'd2000, 10'd0, 10'd99, 10'd99, 10'd99, 10'd0));
    send_sample(sample_of(1'b0, 12'd2000, 10'd0, 10'd99, 10'd100, 10'd99, 10'd0));
    // branch on either side just above the threshold, then both at it
    send_sample(sample_of(1'b0, 12'd2000, 10'd201, 10'd500, 10'd500, 10'd500, 10'd0));
    send_sample(sample_of(1'b0, 12'd2000, 10'd0, 10'd500, 10'd500, 10'd500, 10'd201));
    send_sample(sample_of(1'b0, 12'd2000, 10'd200, 10'd500, 10'd500, 10'd500, 10'd200));
  endtask

  // field and register extremes, zero speed, over-wide register writes
  task automatic test_field_extremes();
    program_regs(12'd255, 12'd0, 12'd0, 12'd1023);
    send_sample(sample_of(1'b1, 12'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    send_sample(sample_of(1'b0, 12'd4095, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                          10'd1023));
    send_sample(sample_of(1'b0, 12'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd1023));
    program_regs(12'd255, 12'd4095, 12'd1023, 12'd0);
    send_sample(sample_of(1'b1, 12'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0));
    send_sample(sample_of(1'b0, 12'd4095, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                          10'd1023));
    send_sample(sample_of(1'b0, 12'd0, 10'd0, 10'd1022, 10'd1022, 10'd1022, 10'd1));
    // zero speed clamps everything to a standstill
    program_regs(12'd0, 12'd2000, 12'd100, 12'd200);
    send_sample(sample_of(1'b1, 12'd4095, 10'd0, 10'd500, 10'd500, 10'd500, 10'd0));
    send_sample(sample_of(1'b0, 12'd0, 10'd0, 10'd500, 10'd500, 10'd500, 10'd0));
    send_sample(sample_of(1'b1, 12'd2000, 10'd0, 10'd500, 10'd500, 10'd500, 10'd0));
    // all register bits high, the upper ones fall away
    program_regs(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_sample(sample_of(1'b1, 12'd4000, 10'd1023, 10'd1022, 10'd1022, 10'd1022,
                          10'd1023));
    send_sample(sample_of(1'b0, 12'd4095, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd0));
  endtask

  // receiver holds off long enough to fill the block and stall the input
  task automatic test_output_hold();
    logic [11:0] pos;
    int k;
    program_regs(12'd200, 12'd2048, 12'd300, 12'd700);
    idle_on = 1'b0;
    hold_reqs <= hold_reqs + 1;
    pos = near_center();
    for (k = 0; k < 40; k++) begin
      send_sample(track_sample(k == 0, pos));
      pos = walk_pos(pos);
    end
  endtask

  // sender pauses until every drive is out, then picks up the segment
  task automatic test_sender_pause();
    logic [11:0] pos;
    int k;
    idle_on = 1'b1;
    pos = near_center();
    for (k = 0; k < 40; k++) begin
      if (k == 20) quiesce();
      send_sample(track_sample(k == 0, pos));
      pos = walk_pos(pos);
    end
  endtask

  // segments of smooth tracking with random sensor pictures, some noise
  task automatic test_random_tracks();
    logic [11:0] pos;
    int phase, items_left, seg_len, k;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_regs(12'(MAX_SPEED_RST), LINE_CENTER_RST, 12'(LOST_THRESHOLD_RST),
                        12'(BRANCH_THRESHOLD_RST));
        1: program_regs(12'd255, 12'd0, 12'd0, 12'd1023);
        2: program_regs(12'd0, 12'd4095, 12'd1023, 12'd0);
        3: program_regs(12'd255, 12'd4095, 12'd1000, 12'd1000);
        default: program_regs(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      endcase
      items_left = 140;
      while (items_left > 0) begin
        // a quiet stretch now and then
        idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) begin
          send_sample(noise_sample());
          items_left--;
        end else begin
          seg_len = $urandom_range(5, 40);
          pos = near_center();
          for (k = 0; k < seg_len && items_left > 0; k++) begin
            send_sample(track_sample(k == 0, pos));
            pos = walk_pos(pos);
            items_left--;
          end
        end
      end
    end
  endtask

  // full-scale error runs in both directions, integral growing fast
  task automatic test_full_scale_error();
    int k;
    idle_on = 1'b0;
    program_regs(12'd255, 12'd0, 12'(LOST_THRESHOLD_RST), 12'(BRANCH_THRESHOLD_RST));
    for (k = 0; k < FULL_RUN; k++)
      send_sample(sample_of(k == 0, 12'd4095, 10'd0, 10'd500, 10'd500, 10'd500, 10'd0));
    program_regs(12'd255, 12'd4095, 12'(LOST_THRESHOLD_RST), 12'(BRANCH_THRESHOLD_RST));
    for (k = 0; k < FULL_RUN; k++)
      send_sample(sample_of(k == 0, 12'd0, 10'd0, 10'd500, 10'd500, 10'd500, 10'd0));
  endtask

  initial begin : run
    // hold the synchronous reset, then release it at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_output_hold();
    test_sender_pause();
    test_random_tracks();
    // last part of the run, no idling
    test_full_scale_error();

    quiesce();
    if (drive_errors == 0 && expected_drives.size() == 0) begin
      $display("pid_line_follower_step_test: clean");
    end else begin
      $display("pid_line_follower_step_test: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #100_000_000;
    $display("pid_line_follower_step_test: errors");
    $finish;
  end

endmodule

[pid_line_follower_step.f]
src/plf_pkg.sv
src/pid_line_follower_step.sv
bench/pid_line_follower_step_test.sv
